// ===== rtl/rvxu_pkg.sv =====
// Package for the RV32I subset execute unit: opcodes, funct3 codes, ALU
// operations, control bundle and channel word types.
// No dependencies.
`timescale 1ns / 1ps

package rvxu_pkg;

   localparam logic [6:0] OP_R     = 7'h33;
   localparam logic [6:0] OP_I     = 7'h13;
   localparam logic [6:0] OP_LUI   = 7'h37;
   localparam logic [6:0] OP_LOAD  = 7'h03;
   localparam logic [6:0] OP_STORE = 7'h23;
   localparam logic [6:0] OP_JAL   = 7'h6F;
   localparam logic [6:0] OP_BEQ   = 7'h63;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_SRA = 3'd5;
   localparam logic [2:0] F3_OR  = 3'd6;

   localparam logic [31:0] NO_ACCESS_DATA = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_OR,
      ALU_XOR,
      ALU_SRA,
      ALU_PASS,
      ALU_ZERO
   } alu_op_type;

   typedef struct packed {
      logic       reg_write;
      logic       alu_src_imm;
      logic       branch;
      logic       mem_read;
      logic       mem_write;
      logic       mem_to_reg;
      logic       invalid;
      alu_op_type alu_op;
   } ctrl_type;

   typedef struct packed {
      logic [31:0]        instr_word;
      logic signed [31:0] rs1_value;
      logic signed [31:0] rs2_value;
      logic               word_access;
   } req_type;

   typedef struct packed {
      logic               reg_write;
      logic               alu_src_imm;
      logic               branch;
      logic               mem_read;
      logic               mem_write;
      logic               mem_to_reg;
      logic signed [31:0] immediate;
      logic signed [31:0] alu_value;
      logic signed [31:0] mem_data;
      logic               zero;
      logic               invalid;
      logic               mem_fault;
   } rsp_type;

endpackage

// ===== rtl/rvxu_stream_if.sv =====
// Valid/ready channel interface carrying one word of a given payload type.
// No dependencies; the payload type comes from the instantiating module.
`timescale 1ns / 1ps

interface rvxu_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/rvxu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module rvxu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rvxu_decode.sv =====
// Instruction decoder: control bundle and sign-extended immediate.
// Depends on rvxu_pkg.
`timescale 1ns / 1ps

module rvxu_decode
   import rvxu_pkg::*;
(
   input  logic [31:0] instr_word,
   output ctrl_type    ctrl,
   output logic [31:0] immediate
);

   logic [6:0] opcode;
   logic [2:0] funct3;
   logic       f3_ok;
   alu_op_type f3_op;

   assign opcode = instr_word[6:0];
   assign funct3 = instr_word[14:12];

   always_comb begin
      f3_ok = 1'b1;
      f3_op = ALU_ADD;
      unique case (funct3)
         F3_ADD: f3_op = ALU_ADD;
         F3_XOR: f3_op = ALU_XOR;
         F3_OR:  f3_op = ALU_OR;
         F3_SRA: f3_op = ALU_SRA;
         default: f3_ok = 1'b0;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      ctrl.alu_op = ALU_ZERO;
      immediate = '0;
      unique case (opcode)
         OP_R: begin
            ctrl.reg_write = 1'b1;
            ctrl.alu_op    = f3_op;
         end
         OP_I: begin
            ctrl.reg_write   = 1'b1;
            ctrl.alu_src_imm = 1'b1;
            ctrl.alu_op      = f3_op;
            // The shift form takes only the 5-bit shift amount, unsigned.
            if (funct3 == F3_SRA) begin
               immediate = {27'b0, instr_word[24:20]};
            end else begin
               immediate = {{20{instr_word[31]}}, instr_word[31:20]};
            end
         end
         OP_LUI: begin
            ctrl.reg_write   = 1'b1;
            ctrl.alu_src_imm = 1'b1;
            ctrl.alu_op      = ALU_PASS;
            immediate        = {instr_word[31:12], 12'b0};
         end
         OP_LOAD: begin
            ctrl.reg_write   = 1'b1;
            ctrl.alu_src_imm = 1'b1;
            ctrl.mem_read    = 1'b1;
            ctrl.mem_to_reg  = 1'b1;
            ctrl.alu_op      = ALU_ADD;
            immediate        = {{20{instr_word[31]}}, instr_word[31:20]};
         end
         OP_STORE: begin
            ctrl.alu_src_imm = 1'b1;
            ctrl.mem_write   = 1'b1;
            ctrl.alu_op      = ALU_ADD;
            immediate = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
         end
         OP_JAL: begin
            ctrl.reg_write = 1'b1;
            ctrl.branch    = 1'b1;
            ctrl.alu_op    = ALU_ZERO;
            immediate = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                         instr_word[20], instr_word[30:21], 1'b0};
         end
         OP_BEQ: begin
            ctrl.branch = 1'b1;
            ctrl.alu_op = ALU_SUB;
            immediate = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                         instr_word[30:25], instr_word[11:8], 1'b0};
         end
         default: begin
            ctrl.invalid = 1'b1;
         end
      endcase

      // An unsupported funct3 on R or I behaves exactly like an unknown opcode.
      if ((opcode == OP_R || opcode == OP_I) && !f3_ok) begin
         ctrl         = '0;
         ctrl.alu_op  = ALU_ZERO;
         ctrl.invalid = 1'b1;
         immediate    = '0;
      end
   end

endmodule

// ===== rtl/rv32i_subset_execute_unit.sv =====
// Top level of the RV32I subset execute unit: decode, ALU, data store access
// and the two-stage result path. Depends on rvxu_pkg, rvxu_stream_if,
// rvxu_decode and rvxu_ram.
//
//   Channel  Direction  Handshake      Word
//   req_if   in         valid/ready    req_type: instruction, rs1, rs2, size flag
//   rsp_if   out        valid/ready    rsp_type: controls, immediate, ALU, memory
//
// One instruction is taken per cycle unless stalled; its result word passes
// the middle stage, then the output register. Decode, ALU and the store's
// address all settle in the accept cycle, when the data store port is driven;
// the registered read of the store sets the latency. After reset the store is
// cleared one word a cycle, and req_if.ready stays low until that pass is done.
// A stalled result holds the output register and the middle stage; the unit
// keeps accepting as long as the middle stage can move on.
`timescale 1ns / 1ps

module rv32i_subset_execute_unit
   import rvxu_pkg::*;
#(
   parameter int MEM_WORDS = 4096
) (
   input  logic  clock,
   input  logic  reset,
   rvxu_stream_if.sink   req_if,
   rvxu_stream_if.source rsp_if
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [AW-1:0] LastIdx = AW'(MEM_WORDS - 1);

   req_type     req;
   ctrl_type    ctrl;
   logic [31:0] imm;
   logic [31:0] op_b;
   logic [31:0] alu_res;
   logic        is_mem;
   logic        fault;
   logic        req_fire;
   logic        out_load;

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clear_idx_ff, clear_idx_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic          ram_re;
   logic [31:0]   ram_rdata;

   logic    s1_valid_ff, s1_valid_in;
   rsp_type s1_rsp_ff, s1_rsp_in;
   logic    s1_load_ff, s1_load_in;
   logic    s1_word_ff, s1_word_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign req = req_if.payload;

   rvxu_decode u_decode (
      .instr_word (req.instr_word),
      .ctrl       (ctrl),
      .immediate  (imm)
   );

   assign op_b = ctrl.alu_src_imm ? imm : req.rs2_value;

   always_comb begin
      case (ctrl.alu_op)
         ALU_ADD:  alu_res = req.rs1_value + op_b;
         ALU_SUB:  alu_res = req.rs1_value - op_b;
         ALU_OR:   alu_res = req.rs1_value | op_b;
         ALU_XOR:  alu_res = req.rs1_value ^ op_b;
         ALU_SRA:  alu_res = req.rs1_value >>> op_b[4:0];
         ALU_PASS: alu_res = op_b;
         default:  alu_res = '0;
      endcase
   end

   // The ALU result is an unsigned byte address; anything past the store faults.
   assign is_mem = ctrl.mem_read || ctrl.mem_write;
   assign fault  = is_mem && (alu_res[31:2] >= 30'(MEM_WORDS));

   assign out_load     = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !clearing_ff && (!s1_valid_ff || out_load);
   assign req_fire     = req_if.valid && req_if.ready;

   // Store and load both use the store in the accept cycle, so a load right
   // after a store to the same word already reads the new data.
   always_comb begin
      clear_idx_in = clear_idx_ff;
      clearing_in  = clearing_ff;
      if (clearing_ff) begin
         clear_idx_in = clear_idx_ff + AW'(1);
         if (clear_idx_ff == LastIdx) begin
            clearing_in = 1'b0;
         end
      end
      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clear_idx_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = req_fire && ctrl.mem_write && !fault;
         ram_waddr = alu_res[AW+1:2];
         ram_wdata = req.word_access ? req.rs2_value : {24'b0, req.rs2_value[7:0]};
      end
      ram_re = req_fire && ctrl.mem_read && !fault;
   end

   rvxu_ram #(
      .WIDTH (32),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (alu_res[AW+1:2]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_rsp_in   = s1_rsp_ff;
      s1_load_in  = s1_load_ff;
      s1_word_in  = s1_word_ff;
      if (out_load) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in           = 1'b1;
         s1_rsp_in.reg_write   = ctrl.reg_write;
         s1_rsp_in.alu_src_imm = ctrl.alu_src_imm;
         s1_rsp_in.branch      = ctrl.branch;
         s1_rsp_in.mem_read    = ctrl.mem_read;
         s1_rsp_in.mem_write   = ctrl.mem_write;
         s1_rsp_in.mem_to_reg  = ctrl.mem_to_reg;
         s1_rsp_in.immediate   = imm;
         s1_rsp_in.alu_value   = alu_res;
         s1_rsp_in.zero        = !ctrl.invalid && (alu_res == '0);
         s1_rsp_in.invalid     = ctrl.invalid;
         s1_rsp_in.mem_fault   = fault;
         s1_rsp_in.mem_data    = (ctrl.mem_write && !fault) ? '0 : NO_ACCESS_DATA;
         s1_load_in            = ctrl.mem_read && !fault;
         s1_word_in            = req.word_access;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = s1_rsp_ff;
         if (s1_load_ff) begin
            rsp_in.mem_data = s1_word_ff ? ram_rdata : {24'b0, ram_rdata[7:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_rsp_ff  <= s1_rsp_in;
      s1_load_ff <= s1_load_in;
      s1_word_ff <= s1_word_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // No instruction may enter while the store is being cleared.
   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_fire)
      else $error("instruction accepted during store clearing");

   // Outside the clearing pass only an in-range store writes the memory.
   a_write_only_for_store : assert property (@(posedge clock) disable iff (reset)
      (ram_we && !clearing_ff) |-> (req_fire && ctrl.mem_write && !fault))
      else $error("data store written by a non-store instruction");

   // A held middle stage must not have its read data overwritten.
   a_no_read_while_held : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |-> !ram_re)
      else $error("store read issued while a load result waits");

   // A waiting middle stage stays valid until it moves to the output.
   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |=> s1_valid_ff)
      else $error("middle stage word lost");

   // An invalid instruction never touches the store.
   a_invalid_no_access : assert property (@(posedge clock) disable iff (reset)
      (req_fire && ctrl.invalid) |-> (!ram_re && !ram_we))
      else $error("invalid instruction accessed the store");

endmodule
